/* hw/rtl/srrip_pkg.sv */
// shared types and constants for the srrip replacement unit
package srrip_pkg;

  localparam int PAGE_W = 32;
  localparam int CAP_W  = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [1:0] RRPV_HIT    = 2'd0;
  localparam logic [1:0] RRPV_INSERT = 2'd2;
  localparam logic [1:0] RRPV_MAX    = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic scan;
    logic dec;
    logic age_start;
    logic age;
    logic push;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic evict;
    logic age_done;
    logic out_free;
  } sts_t;

endpackage

/* hw/rtl/srrip_in_if.sv */
// input channel: one page access per beat
interface srrip_in_if;
  logic                       valid;
  logic                       ready;
  logic [srrip_pkg::PAGE_W-1:0] page;

  modport source (output valid, output page, input ready);
  modport sink (input valid, input page, output ready);
endinterface

/* hw/rtl/srrip_out_if.sv */
// result channel: hit and eviction report per beat
interface srrip_out_if;
  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic                       evicted;
  logic [srrip_pkg::PAGE_W-1:0] evicted_page;

  modport source (output valid, output hit, output evicted, output evicted_page, input ready);
  modport sink (input valid, input hit, input evicted, input evicted_page, output ready);
endinterface

/* hw/rtl/srrip_cfg_if.sv */
// configuration write channel for capacity_in_use
interface srrip_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [srrip_pkg::CAP_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/srrip_dpath.sv */
// srrip datapath: tag and rrpv memories, scan tracking, aging sweep, result register
module srrip_dpath #(
  parameter int ENTRIES  = 64,
  parameter int TAG_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  srrip_pkg::cmd_t     cmd,
  output srrip_pkg::sts_t     sts,
  srrip_in_if.sink            in_ch,
  srrip_out_if.source         out_ch,
  srrip_cfg_if.sink           cfg_ch
);
  import srrip_pkg::*;

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int IW = $clog2(ENTRIES);
  localparam int XW = (CW > CAP_W) ? CW : CAP_W;

  logic [TAG_BITS-1:0] tag_mem  [ENTRIES];
  logic [1:0]          rrpv_mem [ENTRIES];

  logic [CAP_W-1:0]    cap_r;
  logic [CW-1:0]       fill_r;
  logic [CW-1:0]       ptr_r;
  logic [TAG_BITS-1:0] key_r;
  logic                rd_vld_r;
  logic [IW-1:0]       rd_idx_r;
  logic [TAG_BITS-1:0] tag_q_r;
  logic [1:0]          rrpv_q_r;
  logic                match_r;
  logic [IW-1:0]       match_idx_r;
  logic                have_r;
  logic [1:0]          max_r;
  logic [IW-1:0]       vic_idx_r;
  logic [TAG_BITS-1:0] vic_tag_r;
  logic [1:0]          age_r;

  logic                res_hit_r;
  logic                res_ev_r;
  logic [PAGE_W-1:0]   res_page_r;
  logic                out_valid_r;
  logic                out_hit_r;
  logic                out_ev_r;
  logic [PAGE_W-1:0]   out_page_r;

  logic                issue;
  logic                room;
  logic [XW-1:0]       cap_ext;
  logic [XW-1:0]       fill_ext;
  logic [2:0]          aged_sum;
  logic [1:0]          aged_val;
  logic                age_wr;

  assign cfg_ch.ready = 1'b1;

  // effective capacity: zero acts as one, entries beyond the memory are not there
  assign cap_ext  = (cap_r == '0) ? XW'(1) : XW'(cap_r);
  assign fill_ext = XW'(fill_r);
  assign room     = (fill_r < CW'(ENTRIES)) && (fill_ext < cap_ext);

  assign issue = (ptr_r < fill_r) && ((cmd.scan && !match_r) || cmd.age);

  assign aged_sum = {1'b0, rrpv_q_r} + {1'b0, age_r};
  assign aged_val = (aged_sum > {1'b0, RRPV_MAX}) ? RRPV_MAX : aged_sum[1:0];
  assign age_wr   = cmd.age && rd_vld_r;

  assign sts.scan_done = ((ptr_r >= fill_r) || match_r) && !rd_vld_r;
  assign sts.evict     = !match_r && !room;
  assign sts.age_done  = (ptr_r >= fill_r) && !rd_vld_r;
  assign sts.out_free  = !out_valid_r || out_ch.ready;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.hit          = out_hit_r;
  assign out_ch.evicted      = out_ev_r;
  assign out_ch.evicted_page = out_page_r;

  // memory read port, registered data
  always_ff @(posedge clk) begin
    if (issue) begin
      tag_q_r  <= tag_mem[ptr_r[IW-1:0]];
      rrpv_q_r <= rrpv_mem[ptr_r[IW-1:0]];
    end
  end

  // tag write: new line on fill or replacement
  always_ff @(posedge clk) begin
    if (cmd.dec && !match_r) begin
      if (room) begin
        tag_mem[fill_r[IW-1:0]] <= key_r;
      end else begin
        tag_mem[vic_idx_r] <= key_r;
      end
    end
  end

  // rrpv write: hit promote, fill insert, or aging sweep with victim reinsert
  always_ff @(posedge clk) begin
    if (cmd.dec && match_r) begin
      rrpv_mem[match_idx_r] <= RRPV_HIT;
    end else if (cmd.dec && room) begin
      rrpv_mem[fill_r[IW-1:0]] <= RRPV_INSERT;
    end else if (age_wr) begin
      rrpv_mem[rd_idx_r] <= (rd_idx_r == vic_idx_r) ? RRPV_INSERT : aged_val;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_r <= TAG_BITS'(in_ch.page);
    end
    if (issue) begin
      rd_idx_r <= ptr_r[IW-1:0];
    end
    if (cmd.scan && rd_vld_r) begin
      if (!match_r && tag_q_r == key_r) begin
        match_idx_r <= rd_idx_r;
      end
      // first entry holding the largest value becomes the victim after aging
      if (!have_r || rrpv_q_r > max_r) begin
        max_r     <= rrpv_q_r;
        vic_idx_r <= rd_idx_r;
        vic_tag_r <= tag_q_r;
      end
    end
    if (cmd.age_start) begin
      age_r <= RRPV_MAX - max_r;
    end
    if (cmd.dec) begin
      res_hit_r  <= match_r;
      res_ev_r   <= !match_r && !room;
      res_page_r <= (!match_r && !room) ? PAGE_W'(vic_tag_r) : '0;
    end
    if (cmd.push) begin
      out_hit_r  <= res_hit_r;
      out_ev_r   <= res_ev_r;
      out_page_r <= res_page_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      fill_r      <= '0;
      ptr_r       <= '0;
      rd_vld_r    <= 1'b0;
      match_r     <= 1'b0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        cap_r <= cfg_ch.data;
      end
      if (cmd.start || cmd.age_start) begin
        ptr_r <= '0;
      end else if (issue) begin
        ptr_r <= ptr_r + CW'(1);
      end
      rd_vld_r <= issue;
      if (cmd.start) begin
        match_r <= 1'b0;
        have_r  <= 1'b0;
      end else if (cmd.scan && rd_vld_r) begin
        have_r <= 1'b1;
        if (tag_q_r == key_r) begin
          match_r <= 1'b1;
        end
      end
      if (cmd.dec && !match_r && room) begin
        fill_r <= fill_r + CW'(1);
      end
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(ENTRIES))
    else $error("fill count beyond directory size");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_hit_r && out_ev_r))
    else $error("hit reported together with eviction");

  a_evict_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ev_r) |-> (out_page_r == '0))
    else $error("evicted page nonzero without eviction");

  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (!out_valid_r || out_ch.ready))
    else $error("result pushed over a waiting beat");

endmodule

/* hw/rtl/srrip_ctrl.sv */
// srrip controller: sequences lookup scan, decision, aging sweep and result push
module srrip_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  srrip_pkg::sts_t sts,
  output srrip_pkg::cmd_t cmd
);
  import srrip_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_AGE    = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd.dec = 1'b1;
        if (sts.evict) begin
          cmd.age_start = 1'b1;
          state_nxt     = ST_AGE;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_AGE: begin
        cmd.age = 1'b1;
        if (sts.age_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_decide_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DECIDE) |-> ($past(state_r) == ST_SCAN && $past(sts.scan_done)))
    else $error("decision without a finished scan");

  a_accept_to_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_SCAN))
    else $error("accepted beat did not start a scan");

endmodule

/* hw/rtl/srrip_replacement_unit.sv */
// srrip replacement unit top level: fully associative directory with 2-bit static rrip
// a result is pushed once the lookup scan and, on a replacement, the aging sweep are over,
//   and only when the result channel is free
// throughput: one access at a time; set by the one-entry-per-cycle sweeps of the tag and
//   rrpv memories (lookup scan, then aging sweep on a replacement)
// reset: synchronous active-low rst_n empties the directory and sets capacity to 64
module srrip_replacement_unit #(
  parameter int ENTRIES  = 64,
  parameter int TAG_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  srrip_in_if.sink    in_ch,
  srrip_out_if.source out_ch,
  srrip_cfg_if.sink   cfg_ch
);
  import srrip_pkg::*;

  cmd_t cmd;
  sts_t sts;

  srrip_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  srrip_dpath #(
    .ENTRIES  (ENTRIES),
    .TAG_BITS (TAG_BITS)
  ) u_dpath (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .sts    (sts),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

endmodule
